>>> src/ld128_pkg.sv
// Shared types and constants for the 128-by-64 long division unit.
`default_nettype none
package ld128_pkg;
    localparam int WORD_BITS = 128;
    localparam int HALF_BITS = 64;
    // Quotient bits resolved per datapath cycle; keeps the subtract chain short.
    localparam int STEP_BITS = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ld128_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ld128_cmd_t;

    typedef struct packed {
        logic last_step;
        logic div_zero;
    } ld128_status_t;
endpackage
`default_nettype wire

>>> src/long_division_128_by_64_unit.sv
// Top level of the 128-by-64 unsigned long division unit.
`default_nettype none
// Divides a 128-bit unsigned dividend by a 64-bit unsigned divisor and returns the
// 128-bit quotient; the remainder is dropped. One transaction is handled at a time:
// it is accepted in idle, then the datapath resolves four quotient bits per cycle,
// most significant first, over the dividend padded up to whole digits of DIGIT_BITS
// bits, and the result is offered in the cycle after the last step. When the result
// is taken at once the unit is back in idle in the next cycle. The short restoring
// chain holds four bit steps per cycle. A zero divisor skips the bit steps, sets
// divide_by_zero and returns a zero quotient.
module long_division_128_by_64_unit #(
    parameter int DIGIT_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,  // dividend_hi[63:0], dividend_lo[127:64], divisor[191:128]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,  // quotient_hi[63:0], quotient_lo[127:64]
    output logic              m_tuser   // divide_by_zero
);
    import ld128_pkg::*;

    ld128_cmd_t    cmd;
    ld128_status_t status;
    logic [127:0]  quotient;

    ld128_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ld128_datapath #(.DIGIT_BITS(DIGIT_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .dividend_hi (s_tdata[63:0]),
        .dividend_lo (s_tdata[127:64]),
        .divisor     (s_tdata[191:128]),
        .quotient    (quotient)
    );

    assign m_tdata = {quotient[63:0], quotient[127:64]};
    assign m_tuser = status.div_zero;
endmodule
`default_nettype wire

>>> src/ld128_datapath.sv
// Datapath: dividend shift register, partial remainder and quotient assembly.
`default_nettype none
module ld128_datapath #(
    parameter int DIGIT_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ld128_pkg::ld128_cmd_t   cmd,
    output ld128_pkg::ld128_status_t     status,
    input  wire logic [63:0]             dividend_hi,
    input  wire logic [63:0]             dividend_lo,
    input  wire logic [63:0]             divisor,
    output logic [127:0]                 quotient
);
    import ld128_pkg::*;

    localparam int DIGIT_COUNT = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIGIT_SPAN  = DIGIT_COUNT * DIGIT_BITS;
    localparam int STEP_COUNT  = (DIGIT_SPAN + STEP_BITS - 1) / STEP_BITS;
    localparam int NUM_BITS    = STEP_COUNT * STEP_BITS;
    localparam int CW = $clog2(STEP_COUNT);
    localparam int CWS = (CW < 1) ? 1 : CW;

    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [63:0]         rem_reg, rem_next;
    logic [63:0]         div_reg;
    logic [CWS-1:0]      cnt_reg, cnt_next;

    // STEP_BITS restoring bit steps per cycle, so the subtract chain stays short.
    always_comb
    begin
        logic [NUM_BITS-1:0] n;
        logic [63:0]         r;
        logic                carry;
        n = num_reg;
        r = rem_reg;
        for (int b = 0; b < STEP_BITS; b++)
        begin
            carry = r[63];
            r     = {r[62:0], n[NUM_BITS-1]};
            n     = {n[NUM_BITS-2:0], 1'b0};
            if (carry || (r >= div_reg))
            begin
                r    = r - div_reg;
                n[0] = 1'b1;
            end
        end
        num_next = n;
        rem_next = r;
        cnt_next = cnt_reg - CWS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= CWS'(STEP_COUNT - 1);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A partly filled top digit is padded with zeros above bit 127.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= NUM_BITS'({dividend_hi, dividend_lo});
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cmd.step)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign status.last_step = (cnt_reg == '0);
    assign status.div_zero  = (div_reg == '0);
    assign quotient         = status.div_zero ? '0 : num_reg[127:0];
endmodule
`default_nettype wire

>>> src/ld128_ctrl.sv
// Controller state machine sequencing one division transaction.
`default_nettype none
module ld128_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire ld128_pkg::ld128_status_t status,
    output ld128_pkg::ld128_cmd_t         cmd
);
    import ld128_pkg::*;

    ld128_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_RUN;
            ST_RUN:  if (status.last_step || status.div_zero) state_next = ST_DONE;
            ST_DONE: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_RUN:  cmd.step = ~status.div_zero;
            ST_DONE: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the 128-by-64 unsigned long division unit.
module tb;

    // Expected quotients, oldest first, with the check against each accepted result.
    class quotient_board;
        logic [128:0] pending[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        // Predict the result of one accepted division transaction.
        function void note_operands(logic [63:0] n_hi, logic [63:0] n_lo, logic [63:0] d);
            logic [127:0] n;
            logic [127:0] q;
            if (d == 64'd0)
            begin
                pending.push_back({1'b1, 128'd0});
            end
            else
            begin
                n = {n_hi, n_lo};
                q = n / {64'd0, d};
                pending.push_back({1'b0, q});
            end
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_quotient(logic [63:0] q_hi, logic [63:0] q_lo, logic dz);
            logic [128:0] exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result q_hi=%h q_lo=%h dz=%b", q_hi, q_lo, dz);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (exp_r[127:64] !== q_hi)
            begin
                $error("quotient_hi expected %h actual %h", exp_r[127:64], q_hi);
                errors++;
            end
            if (exp_r[63:0] !== q_lo)
            begin
                $error("quotient_lo expected %h actual %h", exp_r[63:0], q_lo);
                errors++;
            end
            if (exp_r[128] !== dz)
            begin
                $error("divide_by_zero expected %b actual %b", exp_r[128], dz);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;

    quotient_board board;
    logic          stim_done;
    logic          hold_req;
    int            idle_cycles;

    long_division_128_by_64_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A 64-bit value of random length so that short and long operands both appear.
    function automatic logic [63:0] rand_sized();
        logic [63:0] v;
        int          len;
        v = rand64();
        len = $urandom_range(64, 1);
        if (len < 64)
            v = v & ((64'd1 << len) - 64'd1);
        if ($urandom_range(7, 0) == 0)
            v = 64'd0;
        return v;
    endfunction

    // Offer one transaction at the falling edge and hold it until it is taken.
    task automatic send_division(logic [63:0] n_hi, logic [63:0] n_lo, logic [63:0] d);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {d, n_lo, n_hi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // The sender works in bursts; valid drops only during a gap between bursts.
    task automatic sender_gap();
        int gap;
        gap = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(30, 1);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Input acceptance feeds the predictor and output acceptance is checked; sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_operands(s_tdata[63:0], s_tdata[127:64], s_tdata[191:128]);
        if (rst_n && m_tvalid && m_tready)
            board.check_quotient(m_tdata[63:0], m_tdata[127:64], m_tuser);
    end

    // The receiver stalls on its own pattern, with one long hold-off on request.
    initial
    begin
        int mode;
        int hold;
        bit hold_used;
        m_tready = 1'b0;
        mode = 0;
        hold = 0;
        hold_used = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_used)
            begin
                hold = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(63, 0) == 0)
                    mode = $urandom_range(2, 0);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(3, 0) != 0);
                    default: m_tready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL long_division_128_by_64_unit");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [63:0] dv;
        int          i;
        int          settle;
        board       = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        stim_done   = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: extremes, division by zero, divisor above dividend, one-digit divisors.
        send_division(64'd0, 64'd0, 64'd0);
        send_division('1, '1, 64'd0);
        send_division('1, '1, '1);
        send_division('1, '1, 64'd1);
        send_division(64'd0, 64'd0, 64'd1);
        send_division(64'd0, 64'd5, 64'd7);
        send_division(64'd0, '1, '1);
        send_division(64'd0, 64'hFFFF_FFFF_FFFF_FFFE, '1);
        send_division(64'h1, 64'd0, 64'hFFFF);
        send_division('1, '1, 64'hFFFF);
        send_division('1, '1, 64'h1_0000);
        send_division('1, '1, 64'h8000_0000_0000_0000);
        send_division(64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0001);
        send_division(64'hFFFF_FFFF_FFFF_FFFE, '1, '1);
        send_division(64'h0000_FFFF_0000_FFFF, 64'h1234_5678_9ABC_DEF0, 64'h1_0001);
        send_division(64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF);
        send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h3);
        send_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_0000_FFFF_0000);

        // Long receiver hold-off while the sender keeps offering transactions.
        hold_req <= 1'b1;
        for (i = 0; i < 30; i++)
            send_division(rand64(), rand64(), rand_sized());
        hold_req <= 1'b0;

        // Random part in bursts with gaps.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            dhi = $urandom_range(3, 0) == 0 ? rand_sized() : rand64();
            dlo = rand64();
            dv  = rand_sized();
            if ($urandom_range(15, 0) == 0)
                dv = '1;
            if ($urandom_range(15, 0) == 0)
                dv = dhi;
            send_division(dhi, dlo, dv);
            if ($urandom_range(7, 0) == 0)
                sender_gap();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        // Drain, then a short settling pause.
        settle = 0;
        while (board.pending.size() != 0 && settle < STALL_LIMIT * 4)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS long_division_128_by_64_unit");
        else
            $display("FAIL long_division_128_by_64_unit");
        $finish;
    end

endmodule

>>> filelist.f
src/ld128_pkg.sv
src/ld128_datapath.sv
src/ld128_ctrl.sv
src/long_division_128_by_64_unit.sv
tb/tb.sv
